// ===== src/sik_pkg.sv =====
// Swerve inverse kinematics package: widths, CSR codes, CORDIC arctangent table,
// gain compensation helpers and the rotator sideband type.
// No dependencies.
`default_nettype none

package sik_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 16;

   localparam int XY_W   = 32;  // command vector, Q30
   localparam int ROT_W  = 34;  // rotator datapath
   localparam int ANG_W  = 34;  // angle accumulator, 1/65536 hundredth degree
   localparam int PRD_W  = 35;  // frame ratio products
   localparam int VEC_W  = 38;  // vectoring datapath
   localparam int MAG_W  = 36;  // wheel magnitude, Q30
   localparam int GH_W   = 55;
   localparam int GL_W   = 46;
   localparam int DIV_STEPS = 16;
   localparam int DIV_W  = 52;
   localparam int SPD_W  = 16;
   localparam int CSR_W  = 16;

   localparam logic [29:0] GAIN_K = 30'd652032874;
   localparam logic signed [ANG_W-1:0] DEG180 = 34'sd1179648000;
   localparam logic [MAG_W-1:0] Q30_ONE = MAG_W'(64'd1073741824);

   localparam logic [1:0] CSR_DEADBAND = 2'd0;
   localparam logic [1:0] CSR_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_WIDTH    = 2'd2;
   localparam logic [1:0] CSR_FIELD    = 2'd3;

   localparam logic [14:0] DEADBAND_RST = 15'd3277;
   localparam logic [15:0] RATIO_RST    = 16'd23170;

   typedef struct packed {
      logic                    stop;
      logic                    fo;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [XY_W-1:0]  r;
   } rot_side_type;

   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd294912000;
         5'd1:  v = 30'd174096719;
         5'd2:  v = 30'd91987925;
         5'd3:  v = 30'd46694507;
         5'd4:  v = 30'd23437865;
         5'd5:  v = 30'd11730358;
         5'd6:  v = 30'd5866610;
         5'd7:  v = 30'd2933484;
         5'd8:  v = 30'd1466764;
         5'd9:  v = 30'd733385;
         5'd10: v = 30'd366693;
         5'd11: v = 30'd183346;
         5'd12: v = 30'd91673;
         5'd13: v = 30'd45837;
         5'd14: v = 30'd22918;
         5'd15: v = 30'd11459;
         5'd16: v = 30'd5730;
         5'd17: v = 30'd2865;
         5'd18: v = 30'd1432;
         5'd19: v = 30'd716;
         5'd20: v = 30'd358;
         5'd21: v = 30'd179;
         5'd22: v = 30'd90;
         5'd23: v = 30'd45;
         default: v = '0;
      endcase
      return v;
   endfunction

   // gain multiply split in two partial products, summed and rounded a stage later
   function automatic logic signed [GH_W-1:0] gain_hi(input logic signed [23:0] h);
      return h * $signed({1'b0, GAIN_K});
   endfunction

   function automatic logic [GL_W-1:0] gain_lo(input logic [15:0] l);
      return l * GAIN_K;
   endfunction

   function automatic logic signed [63:0] gain_sum(input logic signed [GH_W-1:0] ph,
                                                   input logic [GL_W-1:0] pl);
      logic signed [63:0] t;
      t = $signed(64'(ph)) <<< 16;
      t = t + $signed(64'(pl)) + 64'sd536870912;
      return t >>> 30;
   endfunction

endpackage

`default_nettype wire

// ===== src/sik_rotator.sv =====
// Pipelined CORDIC rotation of the command vector by the yaw, with gain compensation.
// Depends on sik_pkg.
`default_nettype none

module sik_rotator
   import sik_pkg::*;
#(
   parameter int ITER = CORDIC_ITERATIONS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [XY_W-1:0]  in_x,
   input  logic signed [XY_W-1:0]  in_y,
   input  logic signed [ANG_W-1:0] in_z,
   input  rot_side_type            in_side,
   output logic                    out_valid,
   output logic signed [XY_W-1:0]  out_x,
   output logic signed [XY_W-1:0]  out_y,
   output rot_side_type            out_side
);

   logic signed [ROT_W-1:0] x_ff [ITER];
   logic signed [ROT_W-1:0] y_ff [ITER];
   logic signed [ANG_W-1:0] z_ff [ITER];
   logic                    v_ff [ITER];
   rot_side_type            side_ff [ITER];

   logic signed [GH_W-1:0]  phx_ff, phy_ff;
   logic [GL_W-1:0]         plx_ff, ply_ff;
   logic                    g1_valid_ff, g2_valid_ff;
   rot_side_type            g1_side_ff, g2_side_ff;
   logic signed [XY_W-1:0]  ox_ff, oy_ff;
   logic signed [63:0]      sumx_in, sumy_in;

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      logic signed [ROT_W-1:0] xs, ys;
      logic signed [ANG_W-1:0] zs, ta;
      logic                    vs;
      rot_side_type            ss;
      if (i == 0) begin : g_head
         assign xs = ROT_W'(in_x);
         assign ys = ROT_W'(in_y);
         assign zs = in_z;
         assign vs = in_valid;
         assign ss = in_side;
      end else begin : g_tail
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
         assign vs = v_ff[i-1];
         assign ss = side_ff[i-1];
      end
      assign ta = $signed(ANG_W'(atan_entry(5'(i))));

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i] <= ss;
            if (!zs[ANG_W-1]) begin
               x_ff[i] <= xs - (ys >>> i);
               y_ff[i] <= ys + (xs >>> i);
               z_ff[i] <= zs - ta;
            end else begin
               x_ff[i] <= xs + (ys >>> i);
               y_ff[i] <= ys - (xs >>> i);
               z_ff[i] <= zs + ta;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_valid_ff <= 1'b0;
         g2_valid_ff <= 1'b0;
      end else if (en) begin
         g1_valid_ff <= v_ff[ITER-1];
         g2_valid_ff <= g1_valid_ff;
      end
   end

   assign sumx_in = gain_sum(phx_ff, plx_ff);
   assign sumy_in = gain_sum(phy_ff, ply_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         phx_ff     <= gain_hi(24'(x_ff[ITER-1] >>> 16));
         phy_ff     <= gain_hi(24'(y_ff[ITER-1] >>> 16));
         plx_ff     <= gain_lo(x_ff[ITER-1][15:0]);
         ply_ff     <= gain_lo(y_ff[ITER-1][15:0]);
         g1_side_ff <= side_ff[ITER-1];
         ox_ff      <= XY_W'(sumx_in);
         oy_ff      <= XY_W'(sumy_in);
         g2_side_ff <= g1_side_ff;
      end
   end

   assign out_valid = g2_valid_ff;
   assign out_x     = ox_ff;
   assign out_y     = oy_ff;
   assign out_side  = g2_side_ff;

endmodule

`default_nettype wire

// ===== src/sik_vector.sv =====
// Four-lane pipelined CORDIC vectoring: steer angle and magnitude per wheel.
// Depends on sik_pkg.
`default_nettype none

module sik_vector
   import sik_pkg::*;
#(
   parameter int ITER = CORDIC_ITERATIONS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic                    in_stop,
   input  logic signed [PRD_W-1:0] in_a,
   input  logic signed [PRD_W-1:0] in_b,
   input  logic signed [PRD_W-1:0] in_c,
   input  logic signed [PRD_W-1:0] in_d,
   output logic                    out_valid,
   output logic                    out_stop,
   output logic signed [15:0]      out_ang [4],
   output logic [MAG_W-1:0]        out_mag [4]
);

   logic signed [PRD_W-1:0] lane_x [4];
   logic signed [PRD_W-1:0] lane_y [4];

   // lanes: left front, left rear, right front, right rear
   assign lane_x[0] = in_c;  assign lane_y[0] = in_b;
   assign lane_x[1] = in_c;  assign lane_y[1] = in_a;
   assign lane_x[2] = in_d;  assign lane_y[2] = in_b;
   assign lane_x[3] = in_d;  assign lane_y[3] = in_a;

   logic signed [VEC_W-1:0] px_ff [4];
   logic signed [VEC_W-1:0] py_ff [4];
   logic signed [ANG_W-1:0] pz_ff [4];
   logic                    pzero_ff [4];
   logic                    p_valid_ff, p_stop_ff;

   logic signed [VEC_W-1:0] x_ff [4][ITER];
   logic signed [VEC_W-1:0] y_ff [4][ITER];
   logic signed [ANG_W-1:0] z_ff [4][ITER];
   logic                    zero_ff [4][ITER];
   logic                    v_ff [ITER];
   logic                    stop_ff [ITER];

   logic signed [GH_W-1:0]  ph_ff [4];
   logic [GL_W-1:0]         pl_ff [4];
   logic signed [15:0]      g1_ang_ff [4];
   logic                    g1_zero_ff [4];
   logic                    g1_valid_ff, g1_stop_ff;
   logic signed [15:0]      g2_ang_ff [4];
   logic [MAG_W-1:0]        g2_mag_ff [4];
   logic                    g2_valid_ff, g2_stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff  <= 1'b0;
         g1_valid_ff <= 1'b0;
         g2_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff  <= in_valid;
         g1_valid_ff <= v_ff[ITER-1];
         g2_valid_ff <= g1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_stop_ff  <= in_stop;
         g1_stop_ff <= stop_ff[ITER-1];
         g2_stop_ff <= g1_stop_ff;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= (i == 0) ? p_valid_ff : v_ff[(i == 0) ? 0 : i-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            stop_ff[i] <= (i == 0) ? p_stop_ff : stop_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic signed [VEC_W-1:0] xe, ye;
      logic signed [ANG_W-1:0] zr;
      logic signed [63:0]      msum;

      assign xe = VEC_W'(lane_x[l]);
      assign ye = VEC_W'(lane_y[l]);

      // left half plane folded over by a half turn
      always_ff @(posedge clock) begin
         if (en) begin
            pzero_ff[l] <= (xe == '0) && (ye == '0);
            if (xe[VEC_W-1]) begin
               px_ff[l] <= -xe;
               py_ff[l] <= -ye;
               pz_ff[l] <= ye[VEC_W-1] ? -DEG180 : DEG180;
            end else begin
               px_ff[l] <= xe;
               py_ff[l] <= ye;
               pz_ff[l] <= '0;
            end
         end
      end

      for (genvar i = 0; i < ITER; i++) begin : g_iter
         logic signed [VEC_W-1:0] xs, ys;
         logic signed [ANG_W-1:0] zs, ta;
         logic                    zf;
         if (i == 0) begin : g_head
            assign xs = px_ff[l];
            assign ys = py_ff[l];
            assign zs = pz_ff[l];
            assign zf = pzero_ff[l];
         end else begin : g_tail
            assign xs = x_ff[l][i-1];
            assign ys = y_ff[l][i-1];
            assign zs = z_ff[l][i-1];
            assign zf = zero_ff[l][i-1];
         end
         assign ta = $signed(ANG_W'(atan_entry(5'(i))));

         always_ff @(posedge clock) begin
            if (en) begin
               zero_ff[l][i] <= zf;
               if (ys[VEC_W-1]) begin
                  x_ff[l][i] <= xs - (ys >>> i);
                  y_ff[l][i] <= ys + (xs >>> i);
                  z_ff[l][i] <= zs - ta;
               end else begin
                  x_ff[l][i] <= xs + (ys >>> i);
                  y_ff[l][i] <= ys - (xs >>> i);
                  z_ff[l][i] <= zs + ta;
               end
            end
         end
      end

      assign zr   = (z_ff[l][ITER-1] + ANG_W'(32768)) >>> 16;
      assign msum = gain_sum(ph_ff[l], pl_ff[l]);

      always_ff @(posedge clock) begin
         if (en) begin
            ph_ff[l]      <= gain_hi(24'(x_ff[l][ITER-1] >>> 16));
            pl_ff[l]      <= gain_lo(x_ff[l][ITER-1][15:0]);
            g1_zero_ff[l] <= zero_ff[l][ITER-1];
            if (zero_ff[l][ITER-1]) begin
               g1_ang_ff[l] <= '0;
            end else if (zr > ANG_W'(18000)) begin
               g1_ang_ff[l] <= 16'sd18000;
            end else if (zr < -ANG_W'(18000)) begin
               g1_ang_ff[l] <= -16'sd18000;
            end else begin
               g1_ang_ff[l] <= 16'(zr);
            end
            g2_ang_ff[l] <= g1_ang_ff[l];
            if (g1_zero_ff[l] || msum[63]) begin
               g2_mag_ff[l] <= '0;
            end else begin
               g2_mag_ff[l] <= MAG_W'(msum);
            end
         end
      end

      assign out_ang[l] = g2_ang_ff[l];
      assign out_mag[l] = g2_mag_ff[l];
   end

   assign out_valid = g2_valid_ff;
   assign out_stop  = g2_stop_ff;

endmodule

`default_nettype wire

// ===== src/sik_normalize.sv =====
// Largest-speed search and pipelined restoring divider scaling speeds to at most 1.0.
// Depends on sik_pkg. The last stage is the result register.
`default_nettype none

module sik_normalize
   import sik_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic               in_stop,
   input  logic signed [15:0] in_ang [4],
   input  logic [MAG_W-1:0]   in_mag [4],
   output logic               out_valid,
   output logic               out_steer,
   output logic signed [15:0] out_ang [4],
   output logic [SPD_W-1:0]   out_spd [4]
);

   localparam int NS = DIV_STEPS;

   logic                m1_valid_ff, m1_stop_ff;
   logic [MAG_W-1:0]    m1_mag_ff [4];
   logic signed [15:0]  m1_ang_ff [4];
   logic [MAG_W-1:0]    m01_ff, m23_ff;

   logic                m2_valid_ff, m2_stop_ff, m2_div_ff;
   logic [MAG_W-1:0]    m2_mx_ff;
   logic [DIV_W-1:0]    m2_rem_ff [4];
   logic [SPD_W-1:0]    m2_quick_ff [4];
   logic signed [15:0]  m2_ang_ff [4];
   logic [MAG_W-1:0]    mx_in;

   logic                d_valid_ff [NS];
   logic                d_stop_ff [NS];
   logic                d_div_ff [NS];
   logic [MAG_W-1:0]    d_mx_ff [NS];
   logic [DIV_W-1:0]    d_rem_ff [4][NS];
   logic [SPD_W-1:0]    d_q_ff [4][NS];
   logic [SPD_W-1:0]    d_quick_ff [4][NS];
   logic signed [15:0]  d_ang_ff [4][NS];

   logic                f_valid_ff, f_steer_ff;
   logic signed [15:0]  f_ang_ff [4];
   logic [SPD_W-1:0]    f_spd_ff [4];

   assign mx_in = (m01_ff > m23_ff) ? m01_ff : m23_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         f_valid_ff  <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= in_valid;
         m2_valid_ff <= m1_valid_ff;
         f_valid_ff  <= d_valid_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_stop_ff <= in_stop;
         m01_ff     <= (in_mag[1] > in_mag[0]) ? in_mag[1] : in_mag[0];
         m23_ff     <= (in_mag[3] > in_mag[2]) ? in_mag[3] : in_mag[2];
         m2_stop_ff <= m1_stop_ff;
         m2_mx_ff   <= mx_in;
         m2_div_ff  <= mx_in > Q30_ONE;
         f_steer_ff <= !d_stop_ff[NS-1];
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (en) begin
            m1_mag_ff[l]   <= in_mag[l];
            m1_ang_ff[l]   <= in_ang[l];
            m2_ang_ff[l]   <= m1_ang_ff[l];
            m2_rem_ff[l]   <= (DIV_W'(m1_mag_ff[l]) << 15) + DIV_W'(mx_in >> 1);
            m2_quick_ff[l] <= SPD_W'((m1_mag_ff[l] + MAG_W'(16384)) >> 15);
            if (d_stop_ff[NS-1]) begin
               f_ang_ff[l] <= '0;
               f_spd_ff[l] <= '0;
            end else begin
               f_ang_ff[l] <= d_ang_ff[l][NS-1];
               f_spd_ff[l] <= d_div_ff[NS-1] ? d_q_ff[l][NS-1] : d_quick_ff[l][NS-1];
            end
         end
      end

      for (genvar j = 0; j < NS; j++) begin : g_step
         logic [DIV_W-1:0]   rs, ds;
         logic [SPD_W-1:0]   qs, ks;
         logic signed [15:0] as;
         logic [MAG_W-1:0]   ms;
         if (j == 0) begin : g_head
            assign rs = m2_rem_ff[l];
            assign qs = '0;
            assign ks = m2_quick_ff[l];
            assign as = m2_ang_ff[l];
            assign ms = m2_mx_ff;
         end else begin : g_tail
            assign rs = d_rem_ff[l][j-1];
            assign qs = d_q_ff[l][j-1];
            assign ks = d_quick_ff[l][j-1];
            assign as = d_ang_ff[l][j-1];
            assign ms = d_mx_ff[j-1];
         end
         assign ds = DIV_W'(ms) << (NS-1-j);

         always_ff @(posedge clock) begin
            if (en) begin
               d_quick_ff[l][j] <= ks;
               d_ang_ff[l][j]   <= as;
               if (rs >= ds) begin
                  d_rem_ff[l][j] <= rs - ds;
                  d_q_ff[l][j]   <= qs | (SPD_W'(1) << (NS-1-j));
               end else begin
                  d_rem_ff[l][j] <= rs;
                  d_q_ff[l][j]   <= qs;
               end
            end
         end
      end

      assign out_ang[l] = f_ang_ff[l];
      assign out_spd[l] = f_spd_ff[l];
   end

   for (genvar j = 0; j < NS; j++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[j] <= 1'b0;
         end else if (en) begin
            d_valid_ff[j] <= (j == 0) ? m2_valid_ff : d_valid_ff[(j == 0) ? 0 : j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            d_stop_ff[j] <= (j == 0) ? m2_stop_ff : d_stop_ff[(j == 0) ? 0 : j-1];
            d_div_ff[j]  <= (j == 0) ? m2_div_ff  : d_div_ff[(j == 0) ? 0 : j-1];
            d_mx_ff[j]   <= (j == 0) ? m2_mx_ff   : d_mx_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   assign out_valid = f_valid_ff;
   assign out_steer = f_steer_ff;

endmodule

`default_nettype wire

// ===== src/swerve_inverse_kinematics_unit.sv =====
// Four-module swerve drive inverse kinematics, top level.
// One transaction per cycle while no result waits on rsp_tready.
// The pipeline advances as a whole; it holds while a result waits on rsp_tready.
// Synchronous reset clears all valid bits and loads the CSR defaults.
// Depends on sik_pkg, sik_rotator, sik_vector, sik_normalize.
`default_nettype none

module swerve_inverse_kinematics_unit
   import sik_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // cmd_strafe, cmd_forward, cmd_rotate, yaw_angle
   input  logic [63:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // angle lf, lr, rf, rr, speed lf, lr, rf, rr
   output logic [127:0]      rsp_tdata,
   // steer_valid
   output logic [0:0]        rsp_tuser,
   input  logic              csr_we,
   input  logic [1:0]        csr_addr,
   input  logic [CSR_W-1:0]  csr_wdata
);

   logic [14:0] deadband_ff;
   logic [15:0] length_ff, width_ff;
   logic        field_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff <= DEADBAND_RST;
         length_ff   <= RATIO_RST;
         width_ff    <= RATIO_RST;
         field_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEADBAND: deadband_ff <= csr_wdata[14:0];
            CSR_LENGTH:   length_ff   <= csr_wdata;
            CSR_WIDTH:    width_ff    <= csr_wdata;
            CSR_FIELD:    field_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // input stage: deadband, negate, yaw wrap and quarter turn
   logic signed [15:0]      sx, fy, rr, yaw;
   logic [16:0]             mag_sx, mag_fy, mag_rr;
   logic signed [XY_W-1:0]  nx, ny;
   logic signed [16:0]      yw, yq;
   logic signed [XY_W-1:0]  qx, qy;

   assign sx  = $signed(req_tdata[15:0]);
   assign fy  = $signed(req_tdata[31:16]);
   assign rr  = $signed(req_tdata[47:32]);
   assign yaw = $signed(req_tdata[63:48]);

   assign mag_sx = sx[15] ? 17'(-17'(sx)) : 17'(sx);
   assign mag_fy = fy[15] ? 17'(-17'(fy)) : 17'(fy);
   assign mag_rr = rr[15] ? 17'(-17'(rr)) : 17'(rr);

   assign nx = -(XY_W'(sx) <<< 15);
   assign ny = -(XY_W'(fy) <<< 15);

   always_comb begin
      yw = 17'(yaw);
      if (yaw > 16'sd18000) begin
         yw = 17'(yaw) - 17'sd36000;
      end else if (yaw < -16'sd18000) begin
         yw = 17'(yaw) + 17'sd36000;
      end
      yq = yw;
      qx = nx;
      qy = ny;
      if (yw > 17'sd9000) begin
         qx = -ny;
         qy = nx;
         yq = yw - 17'sd9000;
      end else if (yw < -17'sd9000) begin
         qx = ny;
         qy = -nx;
         yq = yw + 17'sd9000;
      end
   end

   logic                    s0_valid_ff;
   logic signed [XY_W-1:0]  s0_x_ff, s0_y_ff;
   logic signed [ANG_W-1:0] s0_z_ff;
   rot_side_type            s0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff         <= qx;
         s0_y_ff         <= qy;
         s0_z_ff         <= ANG_W'(yq) <<< 16;
         s0_side_ff.stop <= (mag_sx < {2'b0, deadband_ff}) && (mag_fy < {2'b0, deadband_ff})
                            && (mag_rr < {2'b0, deadband_ff});
         s0_side_ff.fo   <= field_ff;
         s0_side_ff.x    <= nx;
         s0_side_ff.y    <= ny;
         s0_side_ff.r    <= XY_W'(rr) <<< 15;
      end
   end

   logic                   rot_valid;
   logic signed [XY_W-1:0] rot_x, rot_y;
   rot_side_type           rot_side;

   sik_rotator #(.ITER(CORDIC_ITERATIONS)) u_rotator (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_x      (s0_x_ff),
      .in_y      (s0_y_ff),
      .in_z      (s0_z_ff),
      .in_side   (s0_side_ff),
      .out_valid (rot_valid),
      .out_x     (rot_x),
      .out_y     (rot_y),
      .out_side  (rot_side)
   );

   // frame ratio products
   logic signed [XY_W-1:0] px, py;
   logic signed [XY_W:0]   xm, xp, ym, yp;
   logic signed [16:0]     lr17, wr17;
   logic signed [49:0]     ma, mb, mc, md;

   assign px   = rot_side.fo ? rot_x : rot_side.x;
   assign py   = rot_side.fo ? rot_y : rot_side.y;
   assign xm   = (XY_W+1)'(px) - (XY_W+1)'(rot_side.r);
   assign xp   = (XY_W+1)'(px) + (XY_W+1)'(rot_side.r);
   assign ym   = (XY_W+1)'(py) - (XY_W+1)'(rot_side.r);
   assign yp   = (XY_W+1)'(py) + (XY_W+1)'(rot_side.r);
   assign lr17 = $signed({1'b0, length_ff});
   assign wr17 = $signed({1'b0, width_ff});
   assign ma   = (50'(xm) * 50'(lr17) + 50'sd16384) >>> 15;
   assign mb   = (50'(xp) * 50'(lr17) + 50'sd16384) >>> 15;
   assign mc   = (50'(ym) * 50'(wr17) + 50'sd16384) >>> 15;
   assign md   = (50'(yp) * 50'(wr17) + 50'sd16384) >>> 15;

   logic                    p_valid_ff, p_stop_ff;
   logic signed [PRD_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_stop_ff <= rot_side.stop;
         pa_ff     <= PRD_W'(ma);
         pb_ff     <= PRD_W'(mb);
         pc_ff     <= PRD_W'(mc);
         pd_ff     <= PRD_W'(md);
      end
   end

   logic               vec_valid, vec_stop;
   logic signed [15:0] vec_ang [4];
   logic [MAG_W-1:0]   vec_mag [4];

   sik_vector #(.ITER(CORDIC_ITERATIONS)) u_vector (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid_ff),
      .in_stop   (p_stop_ff),
      .in_a      (pa_ff),
      .in_b      (pb_ff),
      .in_c      (pc_ff),
      .in_d      (pd_ff),
      .out_valid (vec_valid),
      .out_stop  (vec_stop),
      .out_ang   (vec_ang),
      .out_mag   (vec_mag)
   );

   logic               nrm_steer;
   logic signed [15:0] nrm_ang [4];
   logic [SPD_W-1:0]   nrm_spd [4];

   sik_normalize u_normalize (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vec_valid),
      .in_stop   (vec_stop),
      .in_ang    (vec_ang),
      .in_mag    (vec_mag),
      .out_valid (rsp_tvalid),
      .out_steer (nrm_steer),
      .out_ang   (nrm_ang),
      .out_spd   (nrm_spd)
   );

   assign rsp_tdata = {nrm_spd[3], nrm_spd[2], nrm_spd[1], nrm_spd[0],
                       nrm_ang[3], nrm_ang[2], nrm_ang[1], nrm_ang[0]};
   assign rsp_tuser = nrm_steer;

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("deadband result carries nonzero fields");

   a_speed_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[79:64] <= 16'd32768) && (rsp_tdata[127:112] <= 16'd32768))
      else $error("wheel speed above 1.0");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) >= -16'sd18000)
                     && ($signed(rsp_tdata[15:0]) <= 16'sd18000))
      else $error("steer angle out of range");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
